// File: sv/grammar_rule_expander_assert.svh
// Assertion helpers for the grammar rule expander. They sample on i_clk and
// stay quiet while i_rst_n is low.
`ifndef GRAMMAR_RULE_EXPANDER_ASSERT_SVH
`define GRAMMAR_RULE_EXPANDER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define GRE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define GRE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define GRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/gre_pkg.sv
`timescale 1ns / 1ps

package gre_pkg;

    localparam int MAX_LEVELS_DEF   = 6;
    localparam int RULE_ENTRIES_DEF = 1024;
    localparam int SYMBOL_BITS_DEF  = 16;

    // Bytes delivered per expansion at most, and a counter that can hold it.
    localparam int OUT_CAP = 64;
    localparam int CNT_W   = $clog2(OUT_CAP + 1);

    localparam int OP_W    = 2;
    localparam int LEVEL_W = 3;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TUPLE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] TUPLE_SIZE_RST  = 3'd2;
    localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 3'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_RULE = 2'd0,
        OP_LOAD_LEAF = 2'd1,
        OP_EXPAND    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INT_RD,
        S_LEAF,
        S_FLUSH
    } t_state;

endpackage

// File: sv/grammar_rule_expander.sv
`timescale 1ns / 1ps
// A load transaction writes an in-range entry from idle. An expand transaction walks the
// grammar depth first: each rule read issues, then pushes the child; leaf bytes are read,
// spent levels are popped and a flush closes the walk. The rule and leaf memory ports take
// one read per cycle, and leaf reads hold while the output is full. A byte is shown once the
// next nonzero byte or the end is found, so the last byte can carry its flags. Synchronous
// reset clears control and sets tuple_size 2, level_count 1; rule memories are not cleared.
module grammar_rule_expander #(
    parameter int MAX_LEVELS   = gre_pkg::MAX_LEVELS_DEF,
    parameter int RULE_ENTRIES = gre_pkg::RULE_ENTRIES_DEF,
    parameter int SYMBOL_BITS  = gre_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gre_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gre_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gre_pkg::OP_W-1:0]        i_op,
    input  logic [gre_pkg::LEVEL_W-1:0]     i_table_level,
    input  logic [gre_pkg::INDEX_W-1:0]     i_entry_index,
    input  logic [gre_pkg::VALUE_W-1:0]     i_entry_value,
    input  logic [gre_pkg::VALUE_W-1:0]     i_start_symbol,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gre_pkg::BYTE_W-1:0]      o_text_byte,
    output logic                            o_last_byte,
    output logic                            o_truncated
);

    localparam int IDX_W     = SYMBOL_BITS + 2;
    localparam int WIDE_W    = 40;
    localparam int ENT_W     = $clog2(RULE_ENTRIES);
    localparam int INT_DEPTH = (MAX_LEVELS > 1) ? (MAX_LEVELS - 1) * RULE_ENTRIES : 1;
    localparam int INT_AW    = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;
    localparam int D_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W     = gre_pkg::CNT_W;
    localparam logic [WIDE_W-1:0] RE_W = WIDE_W'(RULE_ENTRIES);

    // Configuration
    logic [gre_pkg::CFG_W-1:0] r_tuple_size;
    logic [gre_pkg::CFG_W-1:0] r_level_count;
    logic [2:0]                w_tsize;
    logic [7:0]                w_lc;
    logic [D_W-1:0]            w_last_lv;

    // Control
    gre_pkg::t_state r_state, n_state;
    logic [D_W-1:0]   r_depth, n_depth, w_depth_up;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend_valid, n_pend_valid;
    logic [7:0]       r_pend_byte, n_pend_byte;
    logic             r_more, n_more;
    logic [IDX_W-1:0] r_base, n_base;
    logic [1:0]       r_k, n_k;
    logic             r_oob, n_oob;

    // Depth-first stack
    logic [SYMBOL_BITS-1:0] r_sym [MAX_LEVELS];
    logic [2:0]             r_pos [MAX_LEVELS];

    // Rule memories
    logic [SYMBOL_BITS-1:0] r_int_mem [INT_DEPTH];
    logic [7:0]             r_leaf_mem [RULE_ENTRIES];
    logic [SYMBOL_BITS-1:0] r_int_q;
    logic [7:0]             r_leaf_q;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_text;
    logic       r_out_last;
    logic       r_out_trunc;

    logic w_slot_free;
    logic w_emit, w_emit_last;
    logic w_int_we, w_leaf_we, w_int_re, w_leaf_re, w_leaf_sel_next;
    logic w_push_child, w_pos_inc, w_start, w_do_pop;
    logic w_ent_ok, w_rule_ok;

    logic [31:0]            w_ev32, w_ss32;
    logic [SYMBOL_BITS-1:0] w_ev_sym, w_ss_sym;
    logic [SYMBOL_BITS-1:0] w_sym_cur, w_sm1, w_child;
    logic [2:0]             w_pos_cur;
    logic                   w_sym_zero;
    logic [IDX_W-1:0]       w_base, w_int_idx, w_leaf_next, w_leaf_idx;
    logic [WIDE_W-1:0]      w_base_wide, w_int_wide, w_next_wide, w_leaf_wide;
    logic                   w_base_oob, w_int_oob, w_next_oob;
    logic [WIDE_W-1:0]      w_int_raddr_wide, w_int_waddr_wide, w_ent_wide;
    logic [INT_AW-1:0]      w_int_raddr, w_int_waddr;
    logic [ENT_W-1:0]       w_leaf_raddr, w_leaf_waddr;
    logic [7:0]             w_leaf_byte;
    logic                   w_leaf_nz;

    // Register values outside their range saturate.
    always_comb begin
        if (r_tuple_size < 3'd2) begin
            w_tsize = 3'd2;
        end else if (r_tuple_size > 3'd4) begin
            w_tsize = 3'd4;
        end else begin
            w_tsize = r_tuple_size;
        end
        w_lc = {5'b0, r_level_count};
        if (w_lc == 8'd0) begin
            w_lc = 8'd1;
        end else if (w_lc > 8'(MAX_LEVELS)) begin
            w_lc = 8'(MAX_LEVELS);
        end
    end
    assign w_last_lv = D_W'(w_lc - 8'd1);

    assign w_ev32   = {16'b0, i_entry_value};
    assign w_ss32   = {16'b0, i_start_symbol};
    assign w_ev_sym = w_ev32[SYMBOL_BITS-1:0];
    assign w_ss_sym = w_ss32[SYMBOL_BITS-1:0];

    assign w_ent_wide = {{(WIDE_W - gre_pkg::INDEX_W){1'b0}}, i_entry_index};
    assign w_ent_ok   = w_ent_wide < RE_W;
    assign w_rule_ok  = (i_table_level != 3'd0) && ({5'b0, i_table_level} < 8'(MAX_LEVELS))
                        && w_ent_ok;
    assign w_int_waddr_wide = {{(WIDE_W - 3){1'b0}}, i_table_level - 3'd1} * RE_W + w_ent_wide;
    assign w_int_waddr  = w_int_waddr_wide[INT_AW-1:0];
    assign w_leaf_waddr = w_ent_wide[ENT_W-1:0];

    // Child index of the symbol on top of the stack.
    assign w_depth_up = r_depth + 1'b1;
    assign w_sym_cur  = r_sym[r_depth];
    assign w_pos_cur  = r_pos[r_depth];
    assign w_sym_zero = (w_sym_cur == '0);
    assign w_sm1      = w_sym_cur - 1'b1;
    assign w_base     = {2'b00, w_sm1} * {{(IDX_W - 3){1'b0}}, w_tsize};
    assign w_int_idx  = w_base + {{(IDX_W - 3){1'b0}}, w_pos_cur};
    assign w_leaf_next = r_base + {{(IDX_W - 2){1'b0}}, r_k + 2'd1};

    assign w_base_wide = {{(WIDE_W - IDX_W){1'b0}}, w_base};
    assign w_int_wide  = {{(WIDE_W - IDX_W){1'b0}}, w_int_idx};
    assign w_next_wide = {{(WIDE_W - IDX_W){1'b0}}, w_leaf_next};
    assign w_base_oob  = w_base_wide >= RE_W;
    assign w_int_oob   = w_int_wide >= RE_W;
    assign w_next_oob  = w_next_wide >= RE_W;

    // Internal level d+1 is table d of the rule memory.
    assign w_int_raddr_wide = {{(WIDE_W - D_W){1'b0}}, r_depth} * RE_W
                              + {{(WIDE_W - ENT_W){1'b0}}, w_int_wide[ENT_W-1:0]};
    assign w_int_raddr  = w_int_raddr_wide[INT_AW-1:0];
    assign w_leaf_idx   = w_leaf_sel_next ? w_leaf_next : w_base;
    assign w_leaf_wide  = {{(WIDE_W - IDX_W){1'b0}}, w_leaf_idx};
    assign w_leaf_raddr = w_leaf_wide[ENT_W-1:0];

    // An index past the table reads as zero.
    assign w_child     = r_oob ? '0 : r_int_q;
    assign w_leaf_byte = r_oob ? 8'd0 : r_leaf_q;
    assign w_leaf_nz   = (w_leaf_byte != 8'd0);

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == gre_pkg::S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_depth         = r_depth;
        n_count         = r_count;
        n_pend_valid    = r_pend_valid;
        n_pend_byte     = r_pend_byte;
        n_more          = r_more;
        n_base          = r_base;
        n_k             = r_k;
        n_oob           = r_oob;
        w_emit          = 1'b0;
        w_emit_last     = 1'b0;
        w_int_we        = 1'b0;
        w_leaf_we       = 1'b0;
        w_int_re        = 1'b0;
        w_leaf_re       = 1'b0;
        w_leaf_sel_next = 1'b0;
        w_push_child    = 1'b0;
        w_pos_inc       = 1'b0;
        w_start         = 1'b0;
        w_do_pop        = 1'b0;
        unique case (r_state)
            gre_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        gre_pkg::OP_LOAD_RULE: w_int_we = w_rule_ok;
                        gre_pkg::OP_LOAD_LEAF: w_leaf_we = w_ent_ok;
                        gre_pkg::OP_EXPAND: begin
                            w_start      = 1'b1;
                            n_depth      = '0;
                            n_count      = '0;
                            n_more       = 1'b0;
                            n_pend_valid = 1'b0;
                            n_state      = gre_pkg::S_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            gre_pkg::S_WALK: begin
                if (r_depth == w_last_lv) begin
                    if (w_sym_zero) begin
                        w_do_pop = 1'b1;
                    end else begin
                        w_leaf_re = 1'b1;
                        n_oob     = w_base_oob;
                        n_base    = w_base;
                        n_k       = 2'd0;
                        n_state   = gre_pkg::S_LEAF;
                    end
                end else if (w_sym_zero) begin
                    // A zero internal symbol ends the whole expansion.
                    n_state = gre_pkg::S_FLUSH;
                end else if (w_pos_cur >= w_tsize) begin
                    w_do_pop = 1'b1;
                end else begin
                    w_int_re  = 1'b1;
                    n_oob     = w_int_oob;
                    w_pos_inc = 1'b1;
                    n_state   = gre_pkg::S_INT_RD;
                end
            end
            gre_pkg::S_INT_RD: begin
                w_push_child = 1'b1;
                n_depth      = w_depth_up;
                n_state      = gre_pkg::S_WALK;
            end
            gre_pkg::S_LEAF: begin
                if (w_leaf_nz && (r_count == CNT_W'(gre_pkg::OUT_CAP))) begin
                    n_more  = 1'b1;
                    n_state = gre_pkg::S_FLUSH;
                end else if (w_leaf_nz && r_pend_valid && !w_slot_free) begin
                    // Hold the read data until the output register drains.
                    n_state = gre_pkg::S_LEAF;
                end else begin
                    if (w_leaf_nz) begin
                        w_emit       = r_pend_valid;
                        n_pend_byte  = w_leaf_byte;
                        n_pend_valid = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                    if ({1'b0, r_k} == w_tsize - 3'd1) begin
                        w_do_pop = 1'b1;
                    end else begin
                        n_k             = r_k + 2'd1;
                        w_leaf_re       = 1'b1;
                        w_leaf_sel_next = 1'b1;
                        n_oob           = w_next_oob;
                    end
                end
            end
            gre_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = gre_pkg::S_IDLE;
                end else if (w_slot_free) begin
                    w_emit       = 1'b1;
                    w_emit_last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = gre_pkg::S_IDLE;
                end
            end
            default: n_state = gre_pkg::S_IDLE;
        endcase
        if (w_do_pop) begin
            if (r_depth == '0) begin
                n_state = gre_pkg::S_FLUSH;
            end else begin
                n_depth = r_depth - 1'b1;
                n_state = gre_pkg::S_WALK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gre_pkg::S_IDLE;
            r_depth       <= '0;
            r_count       <= '0;
            r_pend_valid  <= 1'b0;
            r_more        <= 1'b0;
            r_tuple_size  <= gre_pkg::TUPLE_SIZE_RST;
            r_level_count <= gre_pkg::LEVEL_COUNT_RST;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_more       <= n_more;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gre_pkg::CFG_TUPLE_SIZE:  r_tuple_size  <= i_cfg_data;
                    gre_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte <= n_pend_byte;
        r_base      <= n_base;
        r_k         <= n_k;
        r_oob       <= n_oob;
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_sym[0] <= w_ss_sym;
            r_pos[0] <= 3'd0;
        end
        if (w_pos_inc) begin
            r_pos[r_depth] <= w_pos_cur + 3'd1;
        end
        if (w_push_child) begin
            r_sym[w_depth_up] <= w_child;
            r_pos[w_depth_up] <= 3'd0;
        end
    end

    // Writes happen only while idle and reads only during an expansion, so the
    // two never meet on the same entry.
    always_ff @(posedge i_clk) begin
        if (w_int_we) begin
            r_int_mem[w_int_waddr] <= w_ev_sym;
        end
        if (w_int_re) begin
            r_int_q <= r_int_mem[w_int_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_leaf_we) begin
            r_leaf_mem[w_leaf_waddr] <= i_entry_value[7:0];
        end
        if (w_leaf_re) begin
            r_leaf_q <= r_leaf_mem[w_leaf_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_text  <= r_pend_byte;
            r_out_last  <= w_emit_last;
            r_out_trunc <= w_emit_last && r_more;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_text_byte = r_out_text;
    assign o_last_byte = r_out_last;
    assign o_truncated = r_out_trunc;

`include "grammar_rule_expander_assert.svh"

    `GRE_ASSERT_ALWAYS(a_count_cap, r_count <= CNT_W'(gre_pkg::OUT_CAP), "byte count past cap")
    `GRE_ASSERT_IMPLY(a_pend_count, r_pend_valid, r_count != '0, "pending byte not counted")
    `GRE_ASSERT_IMPLY(a_trunc_last, o_out_valid && o_truncated, o_last_byte, "truncated not last")
    `GRE_ASSERT_NEXT(a_expand_start, o_in_ready && i_in_valid && (i_op == gre_pkg::OP_EXPAND), (r_state == gre_pkg::S_WALK) && (r_count == '0), "expand did not start walk")

endmodule
